// ===== sv/pid_derivative_on_measurement_defines.svh =====
// ----------------------------------------------------------------------------
// PID derivative-on-measurement assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PID_DERIVATIVE_ON_MEASUREMENT_DEFINES_SVH
`define PID_DERIVATIVE_ON_MEASUREMENT_DEFINES_SVH

`ifndef SYNTH
// checked on every clock edge outside reset
`define PIDM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pidm check failed");
// checked on every clock edge, reset included
`define PIDM_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("pidm reset check failed");
`else
`define PIDM_ASSERT(lbl, prop)
`define PIDM_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== sv/pidm_pkg.sv =====
// ----------------------------------------------------------------------------
// PID derivative-on-measurement package
// Register indexes, configuration record and shared widths.
// ----------------------------------------------------------------------------
package pidm_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int IDX_W          = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int INTEG_W        = 32;

	// register indexes on the write port
	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_PROP    = 3'd0,
		REG_GAIN_INTEG   = 3'd1,
		REG_GAIN_DERIV   = 3'd2,
		REG_INTEG_UPPER  = 3'd3,
		REG_INTEG_LOWER  = 3'd4,
		REG_DRIVE_OFFSET = 3'd5,
		REG_DRIVE_UPPER  = 3'd6,
		REG_DRIVE_LOWER  = 3'd7
	} reg_idx_t;

	// live configuration handed from the register file to the datapath
	typedef struct packed {
		logic        [15:0]        gain_prop;
		logic        [15:0]        gain_integ;
		logic        [15:0]        gain_deriv;
		logic signed [INTEG_W-1:0] integ_upper;
		logic signed [INTEG_W-1:0] integ_lower;
		logic        [14:0]        drive_offset;
		logic signed [15:0]        drive_upper;
		logic signed [15:0]        drive_lower;
	} cfg_t;

	localparam logic signed [15:0] DRIVE_UPPER_RST = 16'sh7FFF;
	localparam logic signed [15:0] DRIVE_LOWER_RST = 16'sh8000;

endpackage

// ===== sv/pidm_cfg.sv =====
// ----------------------------------------------------------------------------
// PID configuration register file
// Decodes the write port into the eight controller registers.
// ----------------------------------------------------------------------------
module pidm_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [pidm_pkg::IDX_W-1:0]          wr_index,
	input  logic [pidm_pkg::CFG_DATA_W-1:0]     wr_data,
	output pidm_pkg::cfg_t                      cfg
);
	import pidm_pkg::*;

	cfg_t cfg_q;

	// write decode, upper data bits beyond a register's width are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop    <= '0;
			cfg_q.gain_integ   <= '0;
			cfg_q.gain_deriv   <= '0;
			cfg_q.integ_upper  <= '0;
			cfg_q.integ_lower  <= '0;
			cfg_q.drive_offset <= '0;
			cfg_q.drive_upper  <= DRIVE_UPPER_RST;
			cfg_q.drive_lower  <= DRIVE_LOWER_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_GAIN_PROP:    cfg_q.gain_prop    <= wr_data[15:0];
				REG_GAIN_INTEG:   cfg_q.gain_integ   <= wr_data[15:0];
				REG_GAIN_DERIV:   cfg_q.gain_deriv   <= wr_data[15:0];
				REG_INTEG_UPPER:  cfg_q.integ_upper  <= $signed(wr_data[INTEG_W-1:0]);
				REG_INTEG_LOWER:  cfg_q.integ_lower  <= $signed(wr_data[INTEG_W-1:0]);
				REG_DRIVE_OFFSET: cfg_q.drive_offset <= wr_data[14:0];
				REG_DRIVE_UPPER:  cfg_q.drive_upper  <= $signed(wr_data[15:0]);
				REG_DRIVE_LOWER:  cfg_q.drive_lower  <= $signed(wr_data[15:0]);
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/pid_derivative_on_measurement.sv =====
// ----------------------------------------------------------------------------
// PID controller, derivative on measurement
// Positional PID: clamped error integral, Q gains, floor shift, offset and
// output clamping. One drive beat per sample beat.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents (lowest bits first)
//  s_*     | in        | setpoint, measured
//  m_*     | out       | drive
//  wr_*    | in        | register index, register value (no handshake)
//
//  One sample accepted per cycle while s_tready is high; drive is presented on
//  m_* after the input, multiply, sum/shift and output registers.
//  The integral and previous-measurement update closes within the input
//  stage, which is what allows a new sample every cycle while not stalled.
//  Ready is passed back combinationally: a low m_tready holds only the full
//  stages, bubbles are squeezed out, and s_tready drops once all four are full.
//  Reset clears the integral, the previous measurement and all valid bits.
// ----------------------------------------------------------------------------
`include "pid_derivative_on_measurement_defines.svh"

module pid_derivative_on_measurement #(
	parameter int DATA_WIDTH = pidm_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pidm_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// sample stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,  // setpoint, measured
	// drive stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_tdata,  // drive
	// register writes
	input  logic                                   wr_en,
	input  logic [pidm_pkg::IDX_W-1:0]             wr_index,
	input  logic [pidm_pkg::CFG_DATA_W-1:0]        wr_data
);
	import pidm_pkg::*;

	localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int ERR_W = DATA_WIDTH + 1;
	localparam int PE_W  = DATA_WIDTH + 18;
	localparam int PI_W  = INTEG_W + 17;
	localparam int SUM_W = ((PE_W > PI_W) ? PE_W : PI_W) + 2;
	localparam int DRV_W = SUM_W + 1;

	cfg_t cfg;

	pidm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// stage handshake: a stage moves when its successor is empty or moving
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en1, en2, en3, en_out, s_accept;

	assign en_out   = !out_valid_q || m_tready;
	assign en3      = !v_s3 || en_out;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign s_accept = s_tvalid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)    v_s1        <= s_tvalid;
			if (en2)    v_s2        <= v_s1;
			if (en3)    v_s3        <= v_s2;
			if (en_out) out_valid_q <= v_s3;
		end
	end

	// input stage: error, derivative term and integral recurrence
	logic signed [DATA_WIDTH-1:0] sp, meas;
	logic signed [DATA_WIDTH-1:0] prev_meas_q;
	logic signed [INTEG_W-1:0]    integral_q, integral_d;
	logic signed [ERR_W-1:0]      err, dmeas;
	logic signed [INTEG_W:0]      isum, iup, ilo, iclamp_hi, iclamp;

	assign sp    = $signed(s_tdata[DATA_WIDTH-1:0]);
	assign meas  = $signed(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
	assign err   = ERR_W'(sp) - ERR_W'(meas);
	assign dmeas = ERR_W'(meas) - ERR_W'(prev_meas_q);

	always_comb begin
		isum      = (INTEG_W+1)'(integral_q) + (INTEG_W+1)'(err);
		iup       = (INTEG_W+1)'($signed(cfg.integ_upper));
		ilo       = (INTEG_W+1)'($signed(cfg.integ_lower));
		// upper clamp first, lower clamp wins on crossed bounds
		iclamp_hi = (isum > iup) ? iup : isum;
		iclamp    = (iclamp_hi < ilo) ? ilo : iclamp_hi;
		integral_d = (cfg.gain_integ != '0) ? iclamp[INTEG_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q  <= '0;
			prev_meas_q <= '0;
		end else if (s_accept) begin
			integral_q  <= integral_d;
			prev_meas_q <= meas;
		end
	end

	logic signed [ERR_W-1:0]   err_s1, dmeas_s1;
	logic signed [INTEG_W-1:0] integ_s1;

	always_ff @(posedge clk) begin
		if (s_accept) begin
			err_s1   <= err;
			dmeas_s1 <= dmeas;
			integ_s1 <= integral_d;
		end
	end

	// multiply stage: three independent products
	logic signed [PE_W-1:0] pe_s2, pd_s2;
	logic signed [PI_W-1:0] pi_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			pe_s2 <= PE_W'($signed({1'b0, cfg.gain_prop}))  * PE_W'(err_s1);
			pd_s2 <= PE_W'($signed({1'b0, cfg.gain_deriv})) * PE_W'(dmeas_s1);
			pi_s2 <= PI_W'($signed({1'b0, cfg.gain_integ})) * PI_W'(integ_s1);
		end
	end

	// sum stage: exact sum, then floor shift out of the fraction bits
	logic signed [SUM_W-1:0] sum, sh_s3;

	assign sum = SUM_W'(pe_s2) + SUM_W'(pi_s2) - SUM_W'(pd_s2);

	always_ff @(posedge clk) begin
		if (en3 && v_s2) sh_s3 <= sum >>> FRAC_BITS;
	end

	// output stage: offset away from zero, drive clamp, width saturation
	logic signed [DRV_W-1:0] off_ext, drv_off, dup, dlo, drv_hi, drv_lo, drv_sat;
	logic signed [DRV_W-1:0] dmax, dmin;
	logic [DATA_WIDTH-1:0]   drive_q;

	assign dmax = DRV_W'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}));
	assign dmin = DRV_W'($signed({1'b1, {(DATA_WIDTH-1){1'b0}}}));

	always_comb begin
		off_ext = DRV_W'($signed({1'b0, cfg.drive_offset}));
		dup     = DRV_W'($signed(cfg.drive_upper));
		dlo     = DRV_W'($signed(cfg.drive_lower));
		if (sh_s3 > 0)
			drv_off = DRV_W'(sh_s3) + off_ext;
		else if (sh_s3 < 0)
			drv_off = DRV_W'(sh_s3) - off_ext;
		else
			drv_off = '0;
		drv_hi  = (drv_off > dup) ? dup : drv_off;
		drv_lo  = (drv_hi < dlo) ? dlo : drv_hi;
		drv_sat = (drv_lo > dmax) ? dmax : ((drv_lo < dmin) ? dmin : drv_lo);
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s3) drive_q <= drv_sat[DATA_WIDTH-1:0];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(drive_q);

	// checks
	`PIDM_ASSERT(a_integ_cleared, s_accept && cfg.gain_integ == '0 |=> integral_q == '0)
	`PIDM_ASSERT(a_prev_tracks, s_accept |=> prev_meas_q == $past(meas))
	`PIDM_ASSERT(a_integ_bounded, s_accept && cfg.gain_integ != '0 && $signed(cfg.integ_lower) <= $signed(cfg.integ_upper) |=> integral_q <= $past($signed(cfg.integ_upper)) && integral_q >= $past($signed(cfg.integ_lower)))
	`PIDM_ASSERT(a_bubble_accepts, v_s1 && !v_s2 |-> s_tready)
	`PIDM_ASSERT_RST(a_reset_clear, !arst_n |-> !m_tvalid && integral_q == '0 && !v_s1)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the derivative-on-measurement PID controller
// Drives sample beats with bursts and gaps, stalls the drive stream on a
// pattern of its own, and checks every drive beat against a cycle-free
// predictor that keeps its own integral, previous measurement and registers.
// ----------------------------------------------------------------------------
module tb;
	import pidm_pkg::*;

	// Predicts drive values and holds them until the matching beat arrives
	class drive_predictor;
		logic        [15:0] kp, ki, kd;
		logic signed [31:0] integ_hi, integ_lo;
		logic        [14:0] offset;
		logic signed [15:0] drive_hi, drive_lo;
		longint             integ_acc;
		longint             last_meas;
		logic        [15:0] expected_drives[$];
		int                 mismatches;
		int                 samples;
		int                 drives_checked;
		int                 integ_clamps;
		int                 drive_clamps;
		int                 zero_drives;

		function new();
			kp = '0;
			ki = '0;
			kd = '0;
			integ_hi = '0;
			integ_lo = '0;
			offset = '0;
			drive_hi = DRIVE_UPPER_RST;
			drive_lo = DRIVE_LOWER_RST;
			integ_acc = 0;
			last_meas = 0;
			mismatches = 0;
			samples = 0;
			drives_checked = 0;
			integ_clamps = 0;
			drive_clamps = 0;
			zero_drives = 0;
		endfunction

		// mirror of a register write; narrow registers drop their high bits
		function void set_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_GAIN_PROP:    kp = value[15:0];
				REG_GAIN_INTEG:   ki = value[15:0];
				REG_GAIN_DERIV:   kd = value[15:0];
				REG_INTEG_UPPER:  integ_hi = value;
				REG_INTEG_LOWER:  integ_lo = value;
				REG_DRIVE_OFFSET: offset = value[14:0];
				REG_DRIVE_UPPER:  drive_hi = value[15:0];
				REG_DRIVE_LOWER:  drive_lo = value[15:0];
				default: ;
			endcase
		endfunction

		// one accepted sample beat: update state, queue the drive it yields
		function void note_sample(logic signed [15:0] sp, logic signed [15:0] meas);
			longint err;
			longint acc;
			longint drv;
			err = longint'(sp) - longint'(meas);
			samples++;

			// integral: accumulate and clamp, upper bound first
			if (ki != 0) begin
				integ_acc = integ_acc + err;
				if (integ_acc > integ_hi) begin
					integ_acc = integ_hi;
					integ_clamps++;
				end
				if (integ_acc < integ_lo) begin
					integ_acc = integ_lo;
					integ_clamps++;
				end
			end else begin
				integ_acc = 0;
			end

			acc = longint'(kp) * err + longint'(ki) * integ_acc
				- longint'(kd) * (longint'(meas) - last_meas);
			drv = acc >>> FRAC_BITS_DEF;

			// push away from zero, then clamp, lower bound winning when crossed
			if (drv > 0)
				drv = drv + longint'(offset);
			else if (drv < 0)
				drv = drv - longint'(offset);
			else
				zero_drives++;
			if (drv > drive_hi) begin
				drv = drive_hi;
				drive_clamps++;
			end
			if (drv < drive_lo) begin
				drv = drive_lo;
				drive_clamps++;
			end
			if (drv > 32767)
				drv = 32767;
			if (drv < -32768)
				drv = -32768;

			last_meas = meas;
			expected_drives.push_back(drv[15:0]);
		endfunction

		function void check_drive(logic [15:0] got);
			logic [15:0] want;
			if (expected_drives.size() == 0) begin
				$error("drive beat with nothing expected: drive %0d", $signed(got));
				mismatches++;
			end else begin
				want = expected_drives.pop_front();
				drives_checked++;
				if (got !== want) begin
					$error("drive mismatch: expected %0d, actual %0d",
						$signed(want), $signed(got));
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction
	endclass

	localparam int PIPE_DEPTH  = 4;
	localparam int LONG_HOLD   = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int N_PHASES    = 12;
	localparam int PHASE_ITEMS = 150;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // setpoint [15:0], measured [31:16]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // drive [15:0]
	logic        wr_en;
	logic [IDX_W-1:0]      wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	drive_predictor pred;

	int burst_left;
	int no_gaps;
	int hold_off_req;
	int long_holds;
	int settings;
	int idle_cycles;

	pid_derivative_on_measurement u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// check every accepted drive beat
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			pred.check_drive(m_tdata);
	end

	// watchdog: too long without any beat on either stream
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[pid_derivative_on_measurement] ERROR");
			$finish;
		end
	end

	// drive side: stall pattern with changing density, plus a long hold on request
	initial begin
		int stall_pct;
		int pattern_left;
		stall_pct = 0;
		pattern_left = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req != 0) begin
				hold_off_req = 0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_holds++;
			end else begin
				if (pattern_left == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 10;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
					pattern_left = $urandom_range(16, 96);
				end
				pattern_left--;
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
				@(posedge clk);
			end
		end
	end

	// offer one sample and hold it until taken; valid stays high afterwards
	task automatic send_sample(input logic signed [15:0] sp, input logic signed [15:0] meas);
		s_tdata  <= {meas, sp};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred.note_sample(sp, meas);
	endtask

	// sample with burst/gap shaping in front of it
	task automatic offer_sample(input logic signed [15:0] sp, input logic signed [15:0] meas);
		int gap;
		if (burst_left == 0) begin
			gap = (no_gaps != 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		send_sample(sp, meas);
	endtask

	// stop offering and wait for every queued drive beat to come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pred.pending() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		pred.set_reg(idx, value);
	endtask

	// full register set, written only once the pipeline is empty
	task automatic configure(input logic [31:0] kp, input logic [31:0] ki,
		input logic [31:0] kd, input logic [31:0] iu, input logic [31:0] il,
		input logic [31:0] off, input logic [31:0] du, input logic [31:0] dl);
		drain();
		write_reg(REG_GAIN_PROP, kp);
		write_reg(REG_GAIN_INTEG, ki);
		write_reg(REG_GAIN_DERIV, kd);
		write_reg(REG_INTEG_UPPER, iu);
		write_reg(REG_INTEG_LOWER, il);
		write_reg(REG_DRIVE_OFFSET, off);
		write_reg(REG_DRIVE_UPPER, du);
		write_reg(REG_DRIVE_LOWER, dl);
		wr_en <= 1'b0;
		@(posedge clk);
		settings++;
	endtask

	// random bits above the register's width; the block must ignore them
	function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
		logic [31:0] m;
		m = (32'h1 << w) - 32'h1;
		return ($urandom & ~m) | (v & m);
	endfunction

	// gains lean towards small values so that results are not all saturated
	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 512));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'hFFFF;
			2: return 16'h0000;
			3: return 16'h0001;
			default: return 16'h7FFF;
		endcase
	endfunction

	task automatic configure_random();
		logic [31:0] iu, il;
		logic [15:0] du, dl;
		logic [14:0] off;
		case ($urandom_range(0, 3))
			0: begin
				iu = 32'h7FFF_FFFF;
				il = 32'h8000_0000;
			end
			1: begin
				iu = $urandom_range(0, 5000);
				il = -$urandom_range(0, 5000);
			end
			2: begin
				iu = $urandom;
				il = $urandom;
			end
			default: begin
				// crossed bounds
				iu = -$urandom_range(1, 3000);
				il = $urandom_range(1, 3000);
			end
		endcase
		case ($urandom_range(0, 3))
			0: off = '0;
			1: off = 15'h7FFF;
			2: off = 15'($urandom_range(0, 200));
			default: off = 15'($urandom);
		endcase
		case ($urandom_range(0, 2))
			0: begin
				du = DRIVE_UPPER_RST;
				dl = DRIVE_LOWER_RST;
			end
			1: begin
				du = 16'($urandom_range(100, 32767));
				dl = -16'($urandom_range(100, 32768));
			end
			default: begin
				du = 16'($urandom);
				dl = 16'($urandom);
			end
		endcase
		configure(with_junk(32'(pick_gain()), 16), with_junk(32'(pick_gain()), 16),
			with_junk(32'(pick_gain()), 16), iu, il, with_junk(32'(off), 15),
			with_junk(32'(du), 16), with_junk(32'(dl), 16));
	endtask

	initial begin
		logic signed [15:0] sp_track, meas_track, sp, meas;
		int mode;
		int r;

		pred = new();
		burst_left = 0;
		no_gaps = 0;
		hold_off_req = 0;
		long_holds = 0;
		settings = 0;
		idle_cycles = 0;
		sp_track = '0;
		meas_track = '0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		wr_en    <= 1'b0;
		wr_index <= REG_GAIN_PROP;
		wr_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: all gains zero, so every drive is zero
		offer_sample(16'sh7FFF, 16'sh8000);
		offer_sample(16'sh8000, 16'sh7FFF);
		offer_sample(16'sh0000, 16'sh0000);

		// tiny proportional gain: floor of the shift, offset, zero result untouched
		configure(32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd100, 32'h7FFF, 32'hFFFF_8000);
		offer_sample(16'sd0, 16'sd0);
		offer_sample(16'sd1, 16'sd0);
		offer_sample(16'sd0, 16'sd1);
		offer_sample(16'sd255, 16'sd0);
		offer_sample(16'sd256, 16'sd0);
		offer_sample(16'sh7FFF, 16'sh8000);
		offer_sample(16'sh8000, 16'sh7FFF);

		// all gains and the offset at their top, stray high bits in every narrow register write
		configure(32'hABCD_FFFF, 32'h0001_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF, 32'h5A5A_7FFF, 32'hA5A5_8000);
		offer_sample(16'sh7FFF, 16'sh8000);
		offer_sample(16'sh7FFF, 16'sh8000);
		offer_sample(16'sh8000, 16'sh7FFF);
		offer_sample(16'sh0000, 16'sh0000);
		offer_sample(16'shFFFF, 16'shFFFF);
		offer_sample(16'sh0001, 16'sh0001);

		// crossed integral and drive bounds: the lower bound wins in both
		configure(32'd256, 32'd256, 32'd256, -32'sd50, 32'd50, 32'd0,
			32'h0000_FFFB, 32'd5);
		offer_sample(16'sd0, 16'sd0);
		offer_sample(16'sd100, 16'sd0);
		offer_sample(-16'sd100, 16'sd0);
		offer_sample(16'sh7FFF, 16'sh8000);

		// random settings, each with a mix of tracking, wild and extreme samples
		for (int p = 0; p < N_PHASES; p++) begin
			configure_random();
			mode = $urandom_range(0, 2);
			// first phase: long output stall while samples keep coming
			no_gaps = (p == 0);
			if (p == 0)
				hold_off_req = 1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 9);
				if (r == 0) begin
					sp = pick_extreme();
					meas = pick_extreme();
				end else if (mode == 0 || r == 1) begin
					sp = 16'($urandom);
					meas = 16'($urandom);
				end else begin
					if ($urandom_range(0, 19) == 0)
						sp_track = 16'($urandom_range(0, 8000)) - 16'sd4000;
					meas_track = meas_track + 16'($urandom_range(0, 64)) - 16'sd32;
					sp = sp_track;
					meas = meas_track;
				end
				offer_sample(sp, meas);
			end
		end
		no_gaps = 0;

		drain();
		repeat (PIPE_DEPTH * 4) @(posedge clk);

		$display("covered %0d samples under %0d register settings, %0d long output stall(s)",
			pred.samples, settings, long_holds);
		$display("%0d drives checked: %0d integral clamps, %0d drive clamps, %0d zero",
			pred.drives_checked, pred.integ_clamps, pred.drive_clamps, pred.zero_drives);
		if (pred.mismatches == 0 && pred.pending() == 0)
			$display("[pid_derivative_on_measurement] OK");
		else
			$display("[pid_derivative_on_measurement] ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+sv
sv/pidm_pkg.sv
sv/pidm_cfg.sv
sv/pid_derivative_on_measurement.sv
bench/tb.sv
